### sv/ili_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ili_pkg: shared types and codes for the interval list intersection block
// Command codes, sequencer states and the comparator result word.
// ============================================================================
package ili_pkg;

    // Command codes carried in the input tuser field.
    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_RUN    = 2'd2;

    // Bit positions of the flags in the output tuser field.
    localparam int USER_VALID_BIT = 0;
    localparam int USER_DROP_BIT  = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_LL,
        ST_HH,
        ST_OV1,
        ST_OV2,
        ST_LR,
        ST_PUSH_FIN
    } ili_state_t;

    // Result of one signed comparison of x against y.
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

### sv/ili_cmp.sv
`timescale 1ns / 1ps
// ============================================================================
// ili_cmp: shared signed comparator
// Compares two signed fixed-point endpoints and reports less-than and equal.
// ============================================================================
module ili_cmp
    import ili_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic signed [W-1:0] x,
    input  logic signed [W-1:0] y,
    output cmp_res_t            res
);

    always_comb
    begin
        res.lt = (x < y);
        res.eq = (x == y);
    end

endmodule

### sv/interval_list_intersection.sv
`timescale 1ns / 1ps
// ============================================================================
// interval_list_intersection: merge-walk intersection of two interval lists
// Loads intervals into list A or B and, on a run, emits every non-empty
// intersection, then clears both lists and the drop flag.
// ============================================================================
// Sequencing: a load word is taken in ST_IDLE. A run visits at most count_a + count_b - 1
// interval pairs; each pair passes one list memory read (ST_RD) and the steps ST_LL,
// ST_HH, ST_OV1, ST_OV2 and ST_LR on the single shared comparator, and each qualifying
// pair also passes ST_PUSH_FIN, which can wait on m_tready while a result is held.
// Throughput: one word at a time; input tready is low for the whole run.
// Reset: rst_n clears counts, drop flag, sequencer and output valid; lists are read once written.
module interval_list_intersection
    import ili_pkg::*;
#(
    parameter int LIST_DEPTH = 16,
    parameter int VALUE_BITS = 32
)
(
    input  logic clk,
    input  logic rst_n,

    // Input word. s_tdata fields, lowest bit up: lo_value, hi_value,
    // lo_closed, hi_closed, then zero padding.
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((2*VALUE_BITS+2+7)/8)*8-1:0]       s_tdata,
    // s_tuser fields, lowest bit up: command.
    input  logic [1:0]                                s_tuser,

    // Result word. m_tdata fields, lowest bit up: res_lo, res_hi,
    // res_lo_closed, res_hi_closed, then zero padding.
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((2*VALUE_BITS+2+7)/8)*8-1:0]       m_tdata,
    // m_tuser fields, lowest bit up: res_valid, dropped.
    output logic [1:0]                                m_tuser,
    // m_tlast carries res_last.
    output logic                                      m_tlast
);

    localparam int VB    = VALUE_BITS;
    localparam int ENT_W = 2 * VB + 2;
    localparam int DW    = ((ENT_W + 7) / 8) * 8;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    // ------------------------------------------------------------------
    // List memories. One entry holds a whole interval in the same layout
    // as the low bits of s_tdata: lo, hi, lo_closed, hi_closed.
    // ------------------------------------------------------------------
    logic [ENT_W-1:0] mem_a [LIST_DEPTH];
    logic [ENT_W-1:0] mem_b [LIST_DEPTH];
    logic [ENT_W-1:0] rd_a_reg;
    logic [ENT_W-1:0] rd_b_reg;

    logic             wr_a_en;
    logic             wr_b_en;
    logic             rd_en;

    // Control and datapath registers.
    ili_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0] cnt_b_reg, cnt_b_next;
    logic [CNT_W-1:0] ia_reg, ia_next;
    logic [CNT_W-1:0] ib_reg, ib_next;
    logic             drop_reg, drop_next;
    logic             drp_reg, drp_next;
    logic             pend_reg, pend_next;
    logic             fin_reg, fin_next;

    // Comparator flags kept across the steps of one pair.
    logic             ah_lt_bh_reg, ah_lt_bh_next;
    logic             ov1_reg, ov1_next;
    logic             ov2_reg, ov2_next;

    // Candidate borders {closed, value} and the held result.
    logic [VB:0]      l_reg, l_next;
    logic [VB:0]      r_reg, r_next;
    logic [VB:0]      pend_l_reg, pend_l_next;
    logic [VB:0]      pend_r_reg, pend_r_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [DW-1:0]    out_data_reg, out_data_next;
    logic [1:0]       out_user_reg, out_user_next;
    logic             out_last_reg, out_last_next;

    // Fields of the pair under test.
    logic [VB-1:0]    al, ah, bl, bh;
    logic             al_c, ah_c, bl_c, bh_c;

    // Shared comparator operands and result.
    logic [VB-1:0]    cmp_x, cmp_y;
    cmp_res_t         cmp_res;

    logic             s_fire;
    logic             out_free;
    logic             qual;

    assign al   = rd_a_reg[VB-1:0];
    assign ah   = rd_a_reg[2*VB-1:VB];
    assign al_c = rd_a_reg[2*VB];
    assign ah_c = rd_a_reg[2*VB+1];
    assign bl   = rd_b_reg[VB-1:0];
    assign bh   = rd_b_reg[2*VB-1:VB];
    assign bl_c = rd_b_reg[2*VB];
    assign bh_c = rd_b_reg[2*VB+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // The one comparator serves every compare of the walk; the sequencer
    // step picks its operands.
    always_comb
    begin
        case (state_reg)
            ST_LL:
            begin
                cmp_x = al;
                cmp_y = bl;
            end
            ST_HH:
            begin
                cmp_x = ah;
                cmp_y = bh;
            end
            ST_OV1:
            begin
                cmp_x = ah;
                cmp_y = bl;
            end
            ST_OV2:
            begin
                cmp_x = al;
                cmp_y = bh;
            end
            ST_LR:
            begin
                cmp_x = l_reg[VB-1:0];
                cmp_y = r_reg[VB-1:0];
            end
            default:
            begin
                cmp_x = al;
                cmp_y = bl;
            end
        endcase
    end

    ili_cmp #(
        .W (VB)
    ) u_cmp (
        .x   (cmp_x),
        .y   (cmp_y),
        .res (cmp_res)
    );

    // A pair is reported when both overlap tests passed and the result
    // interval is either non-degenerate or has a closed border.
    assign qual = ov1_reg && ov2_reg && (cmp_res.lt || l_reg[VB] || r_reg[VB]);

    always_ff @(posedge clk)
    begin
        if (wr_a_en)
        begin
            mem_a[cnt_a_reg[IDX_W-1:0]] <= s_tdata[ENT_W-1:0];
        end
        if (wr_b_en)
        begin
            mem_b[cnt_b_reg[IDX_W-1:0]] <= s_tdata[ENT_W-1:0];
        end
        if (rd_en)
        begin
            rd_a_reg <= mem_a[ia_reg[IDX_W-1:0]];
            rd_b_reg <= mem_b[ib_reg[IDX_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath updates.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        ia_next        = ia_reg;
        ib_next        = ib_reg;
        drop_next      = drop_reg;
        drp_next       = drp_reg;
        pend_next      = pend_reg;
        fin_next       = fin_reg;
        ah_lt_bh_next  = ah_lt_bh_reg;
        ov1_next       = ov1_reg;
        ov2_next       = ov2_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        pend_l_next    = pend_l_reg;
        pend_r_next    = pend_r_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        wr_a_en        = 1'b0;
        wr_b_en        = 1'b0;
        rd_en          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    case (s_tuser)
                        CMD_LOAD_A:
                        begin
                            if (cnt_a_reg < CNT_W'(LIST_DEPTH))
                            begin
                                wr_a_en    = 1'b1;
                                cnt_a_next = cnt_a_reg + CNT_W'(1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        CMD_LOAD_B:
                        begin
                            if (cnt_b_reg < CNT_W'(LIST_DEPTH))
                            begin
                                wr_b_en    = 1'b1;
                                cnt_b_next = cnt_b_reg + CNT_W'(1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        CMD_RUN:
                        begin
                            ia_next    = '0;
                            ib_next    = '0;
                            pend_next  = 1'b0;
                            drp_next   = drop_reg;
                            state_next = ST_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_RD:
            begin
                if ((ia_reg < cnt_a_reg) && (ib_reg < cnt_b_reg))
                begin
                    rd_en      = 1'b1;
                    state_next = ST_LL;
                end
                else
                begin
                    fin_next   = 1'b1;
                    state_next = ST_PUSH_FIN;
                end
            end

            ST_LL:
            begin
                l_next        = cmp_res.lt ? {bl_c, bl} : {al_c, al};
                state_next    = ST_HH;
            end

            ST_HH:
            begin
                ah_lt_bh_next = cmp_res.lt;
                // On a tie of the rights, list A's border is kept.
                r_next        = (!cmp_res.lt && !cmp_res.eq) ? {bh_c, bh} : {ah_c, ah};
                state_next    = ST_OV1;
            end

            ST_OV1:
            begin
                ov1_next   = !cmp_res.lt;
                state_next = ST_OV2;
            end

            ST_OV2:
            begin
                ov2_next   = cmp_res.lt || cmp_res.eq;
                state_next = ST_LR;
            end

            ST_LR:
            begin
                // The list whose interval ends first moves on; B on a tie.
                if (ah_lt_bh_reg)
                begin
                    ia_next = ia_reg + CNT_W'(1);
                end
                else
                begin
                    ib_next = ib_reg + CNT_W'(1);
                end
                if (qual)
                begin
                    fin_next   = 1'b0;
                    state_next = ST_PUSH_FIN;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end

            ST_PUSH_FIN:
            begin
                // One hit is held back so that the final one can carry last.
                if (fin_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_last_next  = 1'b1;
                        out_user_next[USER_DROP_BIT] = drp_reg;
                        if (pend_reg)
                        begin
                            out_data_next = DW'({pend_r_reg[VB], pend_l_reg[VB],
                                                 pend_r_reg[VB-1:0], pend_l_reg[VB-1:0]});
                            out_user_next[USER_VALID_BIT] = 1'b1;
                        end
                        else
                        begin
                            out_data_next = '0;
                            out_user_next[USER_VALID_BIT] = 1'b0;
                        end
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        drop_next  = 1'b0;
                        pend_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
                else if (!pend_reg || out_free)
                begin
                    if (pend_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_last_next  = 1'b0;
                        out_data_next  = DW'({pend_r_reg[VB], pend_l_reg[VB],
                                              pend_r_reg[VB-1:0], pend_l_reg[VB-1:0]});
                        out_user_next[USER_VALID_BIT] = 1'b1;
                        out_user_next[USER_DROP_BIT]  = drp_reg;
                    end
                    pend_l_next = l_reg;
                    pend_r_next = r_reg;
                    pend_next   = 1'b1;
                    state_next  = ST_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            ia_reg        <= '0;
            ib_reg        <= '0;
            drop_reg      <= 1'b0;
            drp_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            ia_reg        <= ia_next;
            ib_reg        <= ib_next;
            drop_reg      <= drop_next;
            drp_reg       <= drp_next;
            pend_reg      <= pend_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ah_lt_bh_reg <= ah_lt_bh_next;
        ov1_reg      <= ov1_next;
        ov2_reg      <= ov2_next;
        l_reg        <= l_next;
        r_reg        <= r_next;
        pend_l_reg   <= pend_l_next;
        pend_r_reg   <= pend_r_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= CNT_W'(LIST_DEPTH)) && (cnt_b_reg <= CNT_W'(LIST_DEPTH)))
        else $error("list count beyond depth");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> ((ia_reg <= cnt_a_reg) && (ib_reg <= cnt_b_reg)))
        else $error("walk index beyond list count");

    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH_FIN && fin_reg && out_free) |=> (m_tvalid && m_tlast))
        else $error("run finished without a last result");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[USER_VALID_BIT]) |-> m_tlast)
        else $error("empty result not marked last");

endmodule
